@@ hdl/ctd_pkg.sv @@
// Shared types and constants for the chunked transfer decoder.
// Holds the byte class record passed from the front end to the back end.
// No dependencies.
package ctd_pkg;

  // Default limits
  localparam int unsigned MaxLineDef   = 16;
  localparam int unsigned FifoDepthDef = 4;

  // Characters of interest
  localparam logic [7:0] ChrLf = 8'h0A;
  localparam logic [7:0] ChrCr = 8'h0D;

  // Result kind codes
  localparam logic [2:0] KindData    = 3'd0;
  localparam logic [2:0] KindEnd     = 3'd1;
  localparam logic [2:0] KindEmpty   = 3'd2;
  localparam logic [2:0] KindLong    = 3'd3;
  localparam logic [2:0] KindTrailer = 3'd4;

  // Classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic       is_lf;
    logic       is_cr;
    logic       is_blank;
    logic       is_hex;
    logic [3:0] hex_val;
  } class_t;

  // Queue status between the queue and its consumer
  typedef struct packed {
    logic   valid;
    class_t item;
  } q_head_t;

endpackage

@@ hdl/ctd_front.sv @@
// Front end of the chunked transfer decoder: input beat handshake and
// byte classification (LF, CR, blank, hex digit). Uses ctd_pkg.
module ctd_front import ctd_pkg::*; (
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       q_full_i,
  output logic       q_push_o,
  output class_t     q_item_o
);

  logic [7:0] c;
  assign c = s_axis_tdata_i;

  // Take a beat whenever the queue has room
  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  // Classify the byte
  always_comb begin
    q_item_o          = '0;
    q_item_o.data     = c;
    q_item_o.is_lf    = (c == ChrLf);
    q_item_o.is_cr    = (c == ChrCr);
    q_item_o.is_blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) ||
                        (c == 8'h0C) || (c == ChrCr);
    if (c >= 8'h30 && c <= 8'h39) begin
      q_item_o.is_hex  = 1'b1;
      q_item_o.hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      q_item_o.is_hex  = 1'b1;
      q_item_o.hex_val = c[3:0] + 4'd9;
    end
  end

endmodule

@@ hdl/ctd_fifo.sv @@
// Short register queue between the front and back ends of the decoder.
// Carries classified bytes; uses ctd_pkg.
module ctd_fifo import ctd_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  class_t  push_item_i,
  output logic    full_o,
  input  logic    pop_i,
  output q_head_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  class_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ hdl/ctd_back.sv @@
// Back end of the chunked transfer decoder: size line parser, chunk and
// trailer tracking, and the registered result beat. Uses ctd_pkg.
module ctd_back import ctd_pkg::*; #(
  parameter int unsigned MaxLine = MaxLineDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_head_t     head_i,
  output logic        pop_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // [7:0] out_byte, [39:8] payload_count
  output logic [2:0]  m_axis_tuser_o   // [2:0] kind
);

  localparam int unsigned LenW = $clog2(MaxLine);

  typedef enum logic [5:0] {
    PhLine   = 6'b000001,
    PhData   = 6'b000010,
    PhTr1    = 6'b000100,
    PhTr2    = 6'b001000,
    PhTr2Bad = 6'b010000,
    PhHalt   = 6'b100000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [31:0]     remain_q, remain_d;
  logic [LenW-1:0] len_q, len_d;
  class_t          held_q, held_d;
  logic            held_vld_q, held_vld_d;
  logic            dig_done_q, dig_done_d;
  logic            dig_start_q, dig_start_d;
  logic [31:0]     dcnt_q, dcnt_d;

  logic            out_vld_q, out_vld_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic [2:0]      out_kind_q, out_kind_d;
  logic [31:0]     out_cnt_q, out_cnt_d;

  class_t          c;
  logic            emit;
  logic [2:0]      emit_kind;
  logic            acc_en;

  assign c     = head_i.item;
  assign pop_o = head_i.valid && (!out_vld_q || m_axis_tready_i);

  // Parser step for one popped byte
  always_comb begin
    phase_d     = phase_q;
    remain_d    = remain_q;
    len_d       = len_q;
    held_d      = held_q;
    held_vld_d  = held_vld_q;
    dig_done_d  = dig_done_q;
    dig_start_d = dig_start_q;
    dcnt_d      = dcnt_q;
    emit        = 1'b0;
    emit_kind   = KindData;
    acc_en      = 1'b0;
    if (pop_o) begin
      case (phase_q)
        PhLine: begin
          if (c.is_lf) begin
            if (len_q == '0) begin
              emit = 1'b1; emit_kind = KindEmpty; phase_d = PhHalt;
            end else if (remain_q == '0) begin
              emit = 1'b1; emit_kind = KindEnd; phase_d = PhHalt;
            end else begin
              phase_d     = PhData;
              len_d       = '0;
              held_vld_d  = 1'b0;
              held_d      = '0;
              dig_done_d  = 1'b0;
              dig_start_d = 1'b0;
            end
          end else if (len_q >= LenW'(MaxLine - 1)) begin
            emit = 1'b1; emit_kind = KindLong; phase_d = PhHalt;
          end else begin
            // Scan the byte held back one step
            if (held_vld_q && !dig_done_q) begin
              if (!dig_start_q) begin
                if (!held_q.is_blank) begin
                  if (!held_q.is_hex) begin
                    dig_done_d = 1'b1;
                  end else begin
                    dig_start_d = 1'b1;
                    acc_en      = 1'b1;
                  end
                end
              end else if (!held_q.is_hex) begin
                dig_done_d = 1'b1;
              end else begin
                acc_en = 1'b1;
              end
            end
            if (acc_en) begin
              remain_d = (remain_q[31:28] != 4'd0) ? 32'hFFFF_FFFF
                                                    : {remain_q[27:0], held_q.hex_val};
            end
            held_d     = c;
            held_vld_d = 1'b1;
            len_d      = len_q + 1'b1;
          end
        end
        PhData: begin
          dcnt_d   = dcnt_q + 32'd1;
          remain_d = remain_q - 32'd1;
          emit     = 1'b1;
          if (remain_q == 32'd1) begin
            phase_d = PhTr1;
          end
        end
        PhTr1: begin
          phase_d = c.is_cr ? PhTr2 : PhTr2Bad;
        end
        PhTr2: begin
          if (!c.is_lf) begin
            emit = 1'b1; emit_kind = KindTrailer; phase_d = PhHalt;
          end else begin
            phase_d     = PhLine;
            remain_d    = '0;
            len_d       = '0;
            held_d      = '0;
            held_vld_d  = 1'b0;
            dig_done_d  = 1'b0;
            dig_start_d = 1'b0;
          end
        end
        PhTr2Bad: begin
          emit = 1'b1; emit_kind = KindTrailer; phase_d = PhHalt;
        end
        default: begin
          phase_d = PhHalt;
        end
      endcase
    end
  end

  // Output register
  always_comb begin
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_byte_d = out_byte_q;
    out_kind_d = out_kind_q;
    out_cnt_d  = out_cnt_q;
    if (emit) begin
      out_vld_d  = 1'b1;
      out_byte_d = (emit_kind == KindData) ? c.data : 8'd0;
      out_kind_d = emit_kind;
      out_cnt_d  = dcnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLine;
      remain_q    <= '0;
      len_q       <= '0;
      held_q      <= '0;
      held_vld_q  <= 1'b0;
      dig_done_q  <= 1'b0;
      dig_start_q <= 1'b0;
      dcnt_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      remain_q    <= remain_d;
      len_q       <= len_d;
      held_q      <= held_d;
      held_vld_q  <= held_vld_d;
      dig_done_q  <= dig_done_d;
      dig_start_q <= dig_start_d;
      dcnt_q      <= dcnt_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_kind_q <= out_kind_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_cnt_q, out_byte_q};
  assign m_axis_tuser_o  = out_kind_q;

endmodule

@@ hdl/chunked_transfer_decoder_core.sv @@
// Chunked transfer decoder, top level: one raw body byte per input beat.
// Throughput: one byte per cycle while the queue has room; the parser retires
// one byte a cycle while its output beat is empty or taken. Path: the front/back
// queue (FifoDepth entries), then the parser and its registered result beat.
// Reset: asynchronous, active low; clears parser state, queue and output valid.
// Depends on ctd_pkg, ctd_front, ctd_fifo and ctd_back.
module chunked_transfer_decoder_core import ctd_pkg::*; #(
  parameter int unsigned MaxLine   = MaxLineDef,
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] out_byte, [39:8] payload_count
  output logic [2:0]  m_axis_tuser_o    // [2:0] kind
);

  logic    q_full, q_push, q_pop;
  class_t  q_item;
  q_head_t q_head;

  // Handshake and classification
  ctd_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (q_item)
  );

  // Decoupling queue
  ctd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head)
  );

  // Parser and result register
  ctd_back #(
    .MaxLine (MaxLine)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (q_head),
    .pop_o           (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
